/* rtl/core/shield_veto_deadtime_tracker_defines.svh */
// assertion macros shared by the shield veto deadtime tracker modules
// every module that asserts has i_clk and i_rst_n
`ifndef SHIELD_VETO_DEADTIME_TRACKER_DEFINES_SVH
`define SHIELD_VETO_DEADTIME_TRACKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SHVDT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SHVDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/shvdt_pkg.sv */
package shvdt_pkg;

    // geometry
    localparam int PANELS    = 6;
    localparam int CRYSTALS  = 16;
    localparam int PANEL_W   = $clog2(PANELS);
    localparam int CNT_W     = $clog2(CRYSTALS + 1);
    localparam int PAIRS     = (PANELS + 1) / 2;

    // field widths
    localparam int OP_W      = 2;
    localparam int TIME_W    = 48;
    localparam int CODE_W    = 3;
    localparam int CRYSTAL_W = 4;
    localparam int ENERGY_W  = 16;
    localparam int END_W     = TIME_W + 1;
    localparam int DT_W      = 30;
    localparam int THR_W     = ENERGY_W + 1;

    // configuration port
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // deadtime arithmetic
    localparam int PROD_W    = CFG_W + CNT_W;
    localparam int DBL_W     = PROD_W + 1;
    localparam int SUM_W     = (DBL_W + 1 > DT_W + 1) ? DBL_W + 1 : DT_W + 1;
    localparam logic [DT_W-1:0] DT_MAX = {DT_W{1'b1}};

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_HIT     = 2'd1;
    localparam logic [OP_W-1:0] OP_END     = 2'd2;
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    // detector codes
    localparam logic [CODE_W-1:0] DET_X0 = 3'd0;
    localparam logic [CODE_W-1:0] DET_X1 = 3'd1;
    localparam logic [CODE_W-1:0] DET_Y0 = 3'd2;
    localparam logic [CODE_W-1:0] DET_Y1 = 3'd3;
    localparam logic [CODE_W-1:0] DET_Z0 = 3'd4;
    localparam logic [CODE_W-1:0] DET_Z1 = 3'd5;

    // panel assignment
    localparam logic [PANEL_W-1:0] PANEL_X0 = PANEL_W'(0);
    localparam logic [PANEL_W-1:0] PANEL_X1 = PANEL_W'(1);
    localparam logic [PANEL_W-1:0] PANEL_Y0 = PANEL_W'(2);
    localparam logic [PANEL_W-1:0] PANEL_Y1 = PANEL_W'(3);
    localparam logic [PANEL_W-1:0] PANEL_Z0 = PANEL_W'(2);
    localparam logic [PANEL_W-1:0] PANEL_Z1 = PANEL_W'(3);
    localparam logic [CRYSTAL_W-1:0] Z_CRYSTAL = 4'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_DEAD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VETO_WINDOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_FLOOR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_BEFORE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_AFTER      = 3'd5;

    // command kinds between front and back
    typedef logic [1:0] t_cmd_kind;
    localparam t_cmd_kind CMD_START = 2'd0;
    localparam t_cmd_kind CMD_HIT   = 2'd1;
    localparam t_cmd_kind CMD_END   = 2'd2;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

    typedef struct packed {
        t_cmd_kind            kind;
        logic [TIME_W-1:0]    stamp;
        logic [PANEL_W-1:0]   panel;
        logic [CRYSTAL_W-1:0] crystal;
    } t_cmd;

    typedef struct packed {
        logic               ok;
        logic [PANEL_W-1:0] panel;
    } t_map;

    // detector code to panel, z codes only on the center crystal
    function automatic t_map map_panel(input logic [CODE_W-1:0] code,
                                       input logic [CRYSTAL_W-1:0] crystal);
        t_map m;
        m.ok    = 1'b1;
        m.panel = '0;
        unique case (code)
            DET_X0: m.panel = PANEL_X0;
            DET_X1: m.panel = PANEL_X1;
            DET_Y0: m.panel = PANEL_Y0;
            DET_Y1: m.panel = PANEL_Y1;
            DET_Z0: begin
                m.panel = PANEL_Z0;
                m.ok    = (crystal == Z_CRYSTAL);
            end
            DET_Z1: begin
                m.panel = PANEL_Z1;
                m.ok    = (crystal == Z_CRYSTAL);
            end
            default: m.ok = 1'b0;
        endcase
        return m;
    endfunction

endpackage

/* rtl/core/shvdt_queue.sv */
`include "shield_veto_deadtime_tracker_defines.svh"

module shvdt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  shvdt_pkg::t_cmd i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output shvdt_pkg::t_cmd o_cmd,
    input  logic            i_pop
);

    shvdt_pkg::t_cmd r_mem [shvdt_pkg::QUEUE_DEPTH];
    logic [shvdt_pkg::QPTR_W-1:0] r_wr;
    logic [shvdt_pkg::QPTR_W-1:0] r_rd;
    logic [shvdt_pkg::QCNT_W-1:0] r_count;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == shvdt_pkg::QCNT_W'(shvdt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == shvdt_pkg::QPTR_W'(shvdt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == shvdt_pkg::QPTR_W'(shvdt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SHVDT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= shvdt_pkg::QCNT_W'(shvdt_pkg::QUEUE_DEPTH), "queue count past depth")
    `SHVDT_ASSERT_NOW(a_no_push_when_full, i_push, !o_full, "push into a full queue")

endmodule

/* rtl/core/shvdt_front.sv */
module shvdt_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  shvdt_pkg::t_cfg_wr                  i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [shvdt_pkg::OP_W-1:0]          i_operation,
    input  logic [shvdt_pkg::TIME_W-1:0]        i_event_time,
    input  logic [shvdt_pkg::CODE_W-1:0]        i_detector_code,
    input  logic [shvdt_pkg::CRYSTAL_W-1:0]     i_crystal_id,
    input  logic [shvdt_pkg::ENERGY_W-1:0]      i_hit_energy,
    input  logic                                i_q_full,
    output logic                                o_push,
    output shvdt_pkg::t_cmd                     o_cmd
);

    logic [shvdt_pkg::THR_W-1:0] r_thr;
    shvdt_pkg::t_map map;
    logic above;
    logic keep;

    // energy threshold lives here, the rest of the registers sit in the back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '1;
        end else if (i_cfg.we && i_cfg.idx == shvdt_pkg::CFG_ENERGY_THRESHOLD) begin
            r_thr <= i_cfg.data[shvdt_pkg::THR_W-1:0];
        end
    end

    always_comb begin
        map   = shvdt_pkg::map_panel(i_detector_code, i_crystal_id);
        // signed compare, energy zero-extended
        above = $signed({2'b00, i_hit_energy}) > $signed({r_thr[shvdt_pkg::THR_W-1], r_thr});
        keep  = 1'b0;
        o_cmd.kind    = shvdt_pkg::CMD_START;
        o_cmd.stamp   = i_event_time;
        o_cmd.panel   = map.panel;
        o_cmd.crystal = i_crystal_id;
        unique case (i_operation)
            shvdt_pkg::OP_START: keep = 1'b1;
            shvdt_pkg::OP_HIT: begin
                keep       = above && map.ok;
                o_cmd.kind = shvdt_pkg::CMD_HIT;
            end
            shvdt_pkg::OP_END: begin
                keep       = 1'b1;
                o_cmd.kind = shvdt_pkg::CMD_END;
            end
            shvdt_pkg::OP_IGNORED: keep = 1'b0;
            default: keep = 1'b0;
        endcase
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full && keep;

endmodule

/* rtl/core/shvdt_back.sv */
`include "shield_veto_deadtime_tracker_defines.svh"

module shvdt_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  shvdt_pkg::t_cfg_wr              i_cfg,
    input  logic                            i_cmd_valid,
    input  shvdt_pkg::t_cmd                 i_cmd,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_has_veto,
    output logic                            o_shield_dead,
    output logic [shvdt_pkg::END_W-1:0]     o_dead_time_end
);

    localparam int P = shvdt_pkg::PANELS;

    // configuration
    logic [shvdt_pkg::CFG_W-1:0] r_ch;
    logic [shvdt_pkg::CFG_W-1:0] r_vw;
    logic [shvdt_pkg::CFG_W-1:0] r_floor;
    logic [shvdt_pkg::CFG_W-1:0] r_db;
    logic [shvdt_pkg::CFG_W-1:0] r_da;

    // panel state
    logic [shvdt_pkg::TIME_W-1:0]   r_last [P];
    logic [P-1:0]                   r_seen;
    logic [shvdt_pkg::DT_W-1:0]     r_dt   [P];
    logic [shvdt_pkg::CRYSTALS-1:0] r_set  [P];
    logic [shvdt_pkg::CNT_W-1:0]    r_cnt  [P];
    logic [shvdt_pkg::TIME_W-1:0]   r_cur;
    logic                           r_veto;
    logic                           r_dead;

    // result pipe
    logic                           r_s1_valid;
    logic [shvdt_pkg::TIME_W-1:0]   r_s1_last [P];
    logic [P-1:0]                   r_s1_seen;
    logic [shvdt_pkg::DT_W-1:0]     r_s1_dt   [P];
    logic                           r_s1_veto;
    logic                           r_s1_dead;
    logic                           r_s2_valid;
    logic [shvdt_pkg::END_W-1:0]    r_s2_pair [shvdt_pkg::PAIRS];
    logic                           r_s2_veto;
    logic                           r_s2_dead;
    logic                           r_out_valid;
    logic                           r_out_veto;
    logic                           r_out_dead;
    logic [shvdt_pkg::END_W-1:0]    r_out_end;

    logic                           adv;
    logic                           is_end;
    logic [P-1:0]                   sel;
    logic [P-1:0]                   in_veto;
    logic [P-1:0]                   open_win;
    logic [P-1:0]                   join_win;
    logic [P-1:0]                   dup;
    logic                           n_dead_hit;
    logic [shvdt_pkg::CRYSTALS-1:0] onehot;
    logic [shvdt_pkg::END_W-1:0]    exp_dead [P];
    logic [shvdt_pkg::END_W-1:0]    win_end  [P];
    logic [shvdt_pkg::END_W-1:0]    coin_end [P];
    logic [shvdt_pkg::PROD_W-1:0]   prod     [P];
    logic [shvdt_pkg::SUM_W-1:0]    dsum     [P];
    logic [shvdt_pkg::SUM_W-1:0]    floored  [P];
    logic [shvdt_pkg::DT_W-1:0]     n_dt     [P];
    logic [shvdt_pkg::END_W-1:0]    ends     [2*shvdt_pkg::PAIRS];
    logic [shvdt_pkg::END_W-1:0]    n_pair   [shvdt_pkg::PAIRS];
    logic [shvdt_pkg::END_W-1:0]    n_max;

    // whole result pipe moves unless the output is held
    assign adv    = !r_out_valid || i_ready;
    assign o_pop  = adv && i_cmd_valid;
    assign is_end = (i_cmd.kind == shvdt_pkg::CMD_END);
    assign onehot = shvdt_pkg::CRYSTALS'(1) << i_cmd.crystal;

    always_comb begin
        n_dead_hit = 1'b0;
        for (int p = 0; p < P; p++) begin
            sel[p]      = (i_cmd.panel == shvdt_pkg::PANEL_W'(p));
            exp_dead[p] = {1'b0, r_last[p]} + shvdt_pkg::END_W'(r_dt[p]);
            win_end[p]  = {1'b0, r_last[p]} + shvdt_pkg::END_W'(r_vw);
            coin_end[p] = {1'b0, r_last[p]} + shvdt_pkg::END_W'(r_db);
            in_veto[p]  = r_seen[p] && (i_cmd.stamp >= r_last[p])
                          && ({1'b0, i_cmd.stamp} <= win_end[p]);
            open_win[p] = !r_seen[p] || ({1'b0, r_cur} > exp_dead[p]);
            join_win[p] = ({1'b0, r_cur} <= coin_end[p]);
            dup[p]      = |(r_set[p] & onehot);
            n_dead_hit  = n_dead_hit || (sel[p] && !open_win[p] && !join_win[p]);
            // delays plus two channel times per unique crystal, floor, saturate
            prod[p]     = shvdt_pkg::PROD_W'(r_ch) * shvdt_pkg::PROD_W'(r_cnt[p]);
            dsum[p]     = shvdt_pkg::SUM_W'(r_db) + shvdt_pkg::SUM_W'({prod[p], 1'b0})
                          + shvdt_pkg::SUM_W'(r_da);
            floored[p]  = (dsum[p] < shvdt_pkg::SUM_W'(r_floor)) ?
                          shvdt_pkg::SUM_W'(r_floor) : dsum[p];
            if (r_cnt[p] == '0) begin
                n_dt[p] = '0;
            end else if (floored[p] > shvdt_pkg::SUM_W'(shvdt_pkg::DT_MAX)) begin
                n_dt[p] = shvdt_pkg::DT_MAX;
            end else begin
                n_dt[p] = floored[p][shvdt_pkg::DT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch    <= '0;
            r_vw    <= '0;
            r_floor <= '0;
            r_db    <= '0;
            r_da    <= '0;
            r_seen  <= '0;
            r_cur   <= '0;
            r_veto  <= 1'b0;
            r_dead  <= 1'b0;
            for (int p = 0; p < P; p++) begin
                r_last[p] <= '0;
                r_dt[p]   <= '0;
                r_set[p]  <= '0;
                r_cnt[p]  <= '0;
            end
        end else begin
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    shvdt_pkg::CFG_CHANNEL_DEAD: r_ch    <= i_cfg.data;
                    shvdt_pkg::CFG_VETO_WINDOW:  r_vw    <= i_cfg.data;
                    shvdt_pkg::CFG_PULSE_FLOOR:  r_floor <= i_cfg.data;
                    shvdt_pkg::CFG_DELAY_BEFORE: r_db    <= i_cfg.data;
                    shvdt_pkg::CFG_DELAY_AFTER:  r_da    <= i_cfg.data;
                    default: ;
                endcase
            end
            if (o_pop) begin
                unique case (i_cmd.kind)
                    shvdt_pkg::CMD_START: begin
                        r_cur  <= i_cmd.stamp;
                        r_veto <= |in_veto;
                        r_dead <= 1'b0;
                    end
                    shvdt_pkg::CMD_HIT: begin
                        for (int p = 0; p < P; p++) begin
                            if (sel[p] && open_win[p]) begin
                                r_seen[p] <= 1'b1;
                                r_last[p] <= r_cur;
                                r_set[p]  <= onehot;
                                r_cnt[p]  <= shvdt_pkg::CNT_W'(1);
                            end else if (sel[p] && join_win[p] && !dup[p]) begin
                                r_set[p]  <= r_set[p] | onehot;
                                r_cnt[p]  <= r_cnt[p] + 1'b1;
                            end
                        end
                        if (n_dead_hit) begin
                            r_dead <= 1'b1;
                        end
                    end
                    shvdt_pkg::CMD_END: begin
                        for (int p = 0; p < P; p++) begin
                            r_dt[p] <= n_dt[p];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // stage two: per-panel end times and first level of the max tree
    always_comb begin
        for (int k = 0; k < 2*shvdt_pkg::PAIRS; k++) begin
            ends[k] = '0;
        end
        for (int p = 0; p < P; p++) begin
            ends[p] = r_s1_seen[p] ?
                      ({1'b0, r_s1_last[p]} + shvdt_pkg::END_W'(r_s1_dt[p])) : '0;
        end
        for (int k = 0; k < shvdt_pkg::PAIRS; k++) begin
            n_pair[k] = (ends[2*k] > ends[2*k+1]) ? ends[2*k] : ends[2*k+1];
        end
    end

    // stage three: rest of the max over the pairs
    always_comb begin
        n_max = '0;
        for (int k = 0; k < shvdt_pkg::PAIRS; k++) begin
            if (r_s2_pair[k] > n_max) begin
                n_max = r_s2_pair[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= o_pop && is_end;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int p = 0; p < P; p++) begin
                r_s1_last[p] <= r_last[p];
                r_s1_dt[p]   <= n_dt[p];
            end
            r_s1_seen <= r_seen;
            r_s1_veto <= r_veto;
            r_s1_dead <= r_dead;
            for (int k = 0; k < shvdt_pkg::PAIRS; k++) begin
                r_s2_pair[k] <= n_pair[k];
            end
            r_s2_veto  <= r_s1_veto;
            r_s2_dead  <= r_s1_dead;
            r_out_veto <= r_s2_veto;
            r_out_dead <= r_s2_dead;
            r_out_end  <= r_s2_veto ? n_max : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_has_veto      = r_out_veto;
    assign o_shield_dead   = r_out_dead;
    assign o_dead_time_end = r_out_end;

    `SHVDT_ASSERT_NOW(a_end_zero_without_veto, r_out_valid && !r_out_veto, r_out_end == '0, "dead time end set without a veto")
    `SHVDT_ASSERT_NEXT(a_end_enters_pipe, o_pop && is_end, r_s1_valid, "end item lost before stage one")

    for (genvar g = 0; g < P; g++) begin : g_chk
        `SHVDT_ASSERT_NOW(a_count_matches_set, 1'b1, $countones(r_set[g]) == r_cnt[g], "crystal count out of step with set")
        `SHVDT_ASSERT_NOW(a_unseen_empty, !r_seen[g], r_cnt[g] == '0, "unseen panel holds crystals")
    end

endmodule

/* rtl/core/shield_veto_deadtime_tracker.sv */
// shield veto and deadtime tracker
// input channel (i_valid / o_ready) takes one item per cycle: start event,
// shield crystal hit or end event; operation code three is taken and dropped
// hits at or below the energy threshold or on an unmapped detector are dropped
// output channel (o_valid / i_ready) gives one item per end event: veto flag,
// shield dead flag and, when vetoed, the latest panel deadtime end
// an end event passes the stage-one, stage-two and output registers in turn
// throughput: one item per cycle unless the output is held; the rate is set by
// the command queue feeding a back end that retires one command per cycle
// against the panel registers; a held output freezes the three-stage result
// pipe; the 4-entry queue keeps taking items until it fills, then o_ready drops
// configuration port (i_cfg_we / i_cfg_idx / i_cfg_data) writes one register
// per cycle, no wait; write only while the block is idle
// reset (i_rst_n low at a clock edge) clears all panels, flags and the queue,
// and sets the threshold to minus one and the other registers to zero
module shield_veto_deadtime_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [shvdt_pkg::OP_W-1:0]          i_operation,
    input  logic [shvdt_pkg::TIME_W-1:0]        i_event_time,
    input  logic [shvdt_pkg::CODE_W-1:0]        i_detector_code,
    input  logic [shvdt_pkg::CRYSTAL_W-1:0]     i_crystal_id,
    input  logic [shvdt_pkg::ENERGY_W-1:0]      i_hit_energy,
    // result items
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_has_veto,
    output logic                                o_shield_dead,
    output logic [shvdt_pkg::END_W-1:0]         o_dead_time_end,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [shvdt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [shvdt_pkg::CFG_W-1:0]         i_cfg_data
);

    shvdt_pkg::t_cfg_wr cfg;
    shvdt_pkg::t_cmd    push_cmd;
    shvdt_pkg::t_cmd    head_cmd;
    logic               push;
    logic               q_full;
    logic               q_valid;
    logic               pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // front: takes items, applies threshold and panel mapping
    shvdt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_event_time    (i_event_time),
        .i_detector_code (i_detector_code),
        .i_crystal_id    (i_crystal_id),
        .i_hit_energy    (i_hit_energy),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    // short command queue decouples the two sides
    shvdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    // back: panel state updates and result pipe
    shvdt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd_valid     (q_valid),
        .i_cmd           (head_cmd),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_has_veto      (o_has_veto),
        .o_shield_dead   (o_shield_dead),
        .o_dead_time_end (o_dead_time_end)
    );

endmodule

/* tb/shield_veto_deadtime_tracker_tb.sv */
`timescale 1ns / 100ps

module shield_veto_deadtime_tracker_tb;
    import shvdt_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 16;   // queue depth plus result pipe, with margin
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 106;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 33;

    // detector codes and register indexes the block must drop
    localparam logic [CODE_W-1:0]    DET_UNUSED_LO = 3'd6;
    localparam logic [CODE_W-1:0]    DET_UNUSED_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [TIME_W-1:0]    stamp;
        logic [CODE_W-1:0]    code;
        logic [CRYSTAL_W-1:0] crystal;
        logic [ENERGY_W-1:0]  energy;
    } t_shield_item;

    typedef struct packed {
        logic             has_veto;
        logic             shield_dead;
        logic [END_W-1:0] dead_time_end;
    } t_verdict;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_reg_write;

    // ROW_CHECKED carries a verdict typed in by hand, ROW_ITEM uses the tracker
    typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        t_shield_item item;
        t_verdict     want;
        t_reg_write   wr;
    } t_row;

    localparam t_shield_item NO_ITEM    = '0;
    localparam t_verdict     NO_VERDICT = '0;
    localparam t_reg_write   NO_WRITE   = '0;

    // directed part: reset values first, then a small hand-made setting
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        // end event straight out of reset: flags clear, nothing seen
        '{ROW_CHECKED, '{OP_END, 48'd0, DET_X0, 4'd0, 16'd0}, '{1'b0, 1'b0, 49'd0}, NO_WRITE},
        '{ROW_ITEM, '{OP_IGNORED, '1, DET_UNUSED_HI, 4'hF, 16'hFFFF}, NO_VERDICT, NO_WRITE},
        // hit before any start event uses time zero, stamp field is ignored
        '{ROW_ITEM, '{OP_HIT, '1, DET_X0, 4'd0, 16'd0}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_HIT, 48'd0, DET_Z0, Z_CRYSTAL, 16'hFFFF}, NO_VERDICT, NO_WRITE},
        // z hit off the center crystal and unknown codes are dropped
        '{ROW_ITEM, '{OP_HIT, 48'd0, DET_Z1, 4'd3, 16'hFFFF}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_HIT, 48'd0, DET_UNUSED_LO, 4'hF, 16'hFFFF}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_HIT, 48'd0, DET_UNUSED_HI, Z_CRYSTAL, 16'hFFFF}, NO_VERDICT, NO_WRITE},
        '{ROW_CHECKED, '{OP_END, 48'd0, DET_X0, 4'd0, 16'd0}, '{1'b0, 1'b0, 49'd0}, NO_WRITE},
        // start at zero lands on the zero-length window of seen panels
        '{ROW_ITEM, '{OP_START, 48'd0, DET_X0, 4'd0, 16'd0}, NO_VERDICT, NO_WRITE},
        '{ROW_CHECKED, '{OP_END, 48'd0, DET_X0, 4'd0, 16'd0}, '{1'b1, 1'b0, 49'd0}, NO_WRITE},
        '{ROW_CFG, NO_ITEM, NO_VERDICT, '{CFG_ENERGY_THRESHOLD, 24'd100}},
        '{ROW_CFG, NO_ITEM, NO_VERDICT, '{CFG_CHANNEL_DEAD, 24'd10}},
        '{ROW_CFG, NO_ITEM, NO_VERDICT, '{CFG_VETO_WINDOW, 24'd1000}},
        '{ROW_CFG, NO_ITEM, NO_VERDICT, '{CFG_PULSE_FLOOR, 24'd50}},
        '{ROW_CFG, NO_ITEM, NO_VERDICT, '{CFG_DELAY_BEFORE, 24'd5}},
        '{ROW_CFG, NO_ITEM, NO_VERDICT, '{CFG_DELAY_AFTER, 24'd7}},
        '{ROW_ITEM, '{OP_START, 48'd1000, DET_X0, 4'd0, 16'd0}, NO_VERDICT, NO_WRITE},
        // energy equal to the threshold does not count
        '{ROW_ITEM, '{OP_HIT, 48'd0, DET_X1, 4'd2, 16'd100}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_HIT, 48'd0, DET_X1, 4'd2, 16'd101}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_HIT, 48'd0, DET_Y1, 4'hF, 16'hFFFF}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_HIT, 48'd0, DET_X1, 4'd9, 16'd200}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_END, 48'd0, DET_X0, 4'd0, 16'd0}, NO_VERDICT, NO_WRITE},
        // inside the coincidence window: joins the open set
        '{ROW_ITEM, '{OP_START, 48'd1003, DET_X0, 4'd0, 16'd0}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_HIT, 48'd0, DET_X1, 4'd3, 16'd200}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_END, 48'd0, DET_X0, 4'd0, 16'd0}, NO_VERDICT, NO_WRITE},
        // past coincidence but inside deadtime: shield dead
        '{ROW_ITEM, '{OP_START, 48'd1010, DET_X0, 4'd0, 16'd0}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_HIT, 48'd0, DET_X1, 4'd3, 16'd200}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_END, 48'd0, DET_X0, 4'd0, 16'd0}, NO_VERDICT, NO_WRITE},
        // top of the time range, end time spills into bit 48
        '{ROW_ITEM, '{OP_START, '1, DET_X0, 4'd0, 16'd0}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_HIT, 48'd0, DET_Y0, 4'd0, 16'hFFFF}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_END, 48'd0, DET_X0, 4'd0, 16'd0}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_START, '1, DET_X0, 4'd0, 16'd0}, NO_VERDICT, NO_WRITE},
        '{ROW_ITEM, '{OP_END, 48'd0, DET_X0, 4'd0, 16'd0}, NO_VERDICT, NO_WRITE}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [OP_W-1:0]      i_operation;
    logic [TIME_W-1:0]    i_event_time;
    logic [CODE_W-1:0]    i_detector_code;
    logic [CRYSTAL_W-1:0] i_crystal_id;
    logic [ENERGY_W-1:0]  i_hit_energy;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_has_veto;
    logic                 o_shield_dead;
    logic [END_W-1:0]     o_dead_time_end;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    shield_veto_deadtime_tracker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_event_time    (i_event_time),
        .i_detector_code (i_detector_code),
        .i_crystal_id    (i_crystal_id),
        .i_hit_energy    (i_hit_energy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_has_veto      (o_has_veto),
        .o_shield_dead   (o_shield_dead),
        .o_dead_time_end (o_dead_time_end),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // tracker copy of the registers, at their reset values
    logic signed [THR_W-1:0] energy_floor  = '1;
    logic [CFG_W-1:0]        channel_ticks = '0;
    logic [CFG_W-1:0]        window_ticks  = '0;
    logic [CFG_W-1:0]        floor_ticks   = '0;
    logic [CFG_W-1:0]        lead_ticks    = '0;
    logic [CFG_W-1:0]        trail_ticks   = '0;

    // tracker copy of the panel state
    logic [TIME_W-1:0]   panel_hit_time [PANELS] = '{default: '0};
    logic                panel_seen     [PANELS] = '{default: 1'b0};
    logic [DT_W-1:0]     panel_dead     [PANELS] = '{default: '0};
    logic [CRYSTALS-1:0] panel_crystals [PANELS] = '{default: '0};
    logic [TIME_W-1:0]   now_time  = '0;
    logic                veto_flag = 1'b0;
    logic                dead_flag = 1'b0;

    t_verdict          awaited_verdicts [$];
    t_verdict          head_verdict;
    int                mismatch_count = 0;
    int                cycle_count    = 0;
    int                items_sent     = 0;
    int                gap_pct        = 0;
    int                stall_pct      = 0;
    logic [TIME_W-1:0] start_ticks    = '0;
    int                idle_levels [4] = '{0, 10, 30, 60};

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // deadtime of one panel from its crystal set
    function automatic logic [DT_W-1:0] crystal_deadtime(input logic [CRYSTALS-1:0] set);
        longint unsigned d;
        if (set == '0) return '0;
        d = 64'(lead_ticks) + 64'(channel_ticks) * 64'(2 * $countones(set)) + 64'(trail_ticks);
        if (d < 64'(floor_ticks)) d = 64'(floor_ticks);
        if (d > 64'(DT_MAX)) d = 64'(DT_MAX);
        return DT_W'(d);
    endfunction

    // apply one item to the tracker; returns 1 when it yields a verdict
    function automatic bit advance_tracker(input t_shield_item it, output t_verdict v);
        int              g;
        longint unsigned latest;
        v = '0;
        g = -1;
        latest = 0;
        case (it.op)
            OP_START: begin
                now_time  = it.stamp;
                veto_flag = 1'b0;
                dead_flag = 1'b0;
                for (int p = 0; p < PANELS; p++) begin
                    if (panel_seen[p] && now_time >= panel_hit_time[p] &&
                        64'(now_time) <= 64'(panel_hit_time[p]) + 64'(window_ticks))
                        veto_flag = 1'b1;
                end
            end
            OP_HIT: begin
                if (int'(it.energy) <= int'(energy_floor)) return 1'b0;
                case (it.code)
                    DET_X0: g = int'(PANEL_X0);
                    DET_X1: g = int'(PANEL_X1);
                    DET_Y0: g = int'(PANEL_Y0);
                    DET_Y1: g = int'(PANEL_Y1);
                    DET_Z0: if (it.crystal == Z_CRYSTAL) g = int'(PANEL_Z0);
                    DET_Z1: if (it.crystal == Z_CRYSTAL) g = int'(PANEL_Z1);
                    default: g = -1;
                endcase
                if (g < 0) return 1'b0;
                if (!panel_seen[g] ||
                    64'(now_time) > 64'(panel_hit_time[g]) + 64'(panel_dead[g])) begin
                    // new window: set restarts with this crystal
                    panel_seen[g]     = 1'b1;
                    panel_hit_time[g] = now_time;
                    panel_crystals[g] = '0;
                    panel_crystals[g][it.crystal] = 1'b1;
                end else if (64'(now_time) <= 64'(panel_hit_time[g]) + 64'(lead_ticks)) begin
                    panel_crystals[g][it.crystal] = 1'b1;
                end else begin
                    dead_flag = 1'b1;
                end
            end
            OP_END: begin
                for (int p = 0; p < PANELS; p++)
                    panel_dead[p] = crystal_deadtime(panel_crystals[p]);
                if (veto_flag) begin
                    for (int p = 0; p < PANELS; p++) begin
                        if (panel_seen[p] &&
                            64'(panel_hit_time[p]) + 64'(panel_dead[p]) > latest)
                            latest = 64'(panel_hit_time[p]) + 64'(panel_dead[p]);
                    end
                end
                v.has_veto      = veto_flag;
                v.shield_dead   = dead_flag;
                v.dead_time_end = END_W'(latest);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_ENERGY_THRESHOLD: energy_floor  = data[THR_W-1:0];
            CFG_CHANNEL_DEAD:     channel_ticks = data;
            CFG_VETO_WINDOW:      window_ticks  = data;
            CFG_PULSE_FLOOR:      floor_ticks   = data;
            CFG_DELAY_BEFORE:     lead_ticks    = data;
            CFG_DELAY_AFTER:      trail_ticks   = data;
            default: ;
        endcase
    endtask

    // offer one item, optionally after an idle burst, and wait until it is taken
    task automatic send_item(input t_shield_item it, input bit typed, input t_verdict typed_v);
        t_verdict v;
        int       n;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            n = int'($urandom_range(1, 10));
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid         = 1'b1;
        i_operation     = it.op;
        i_event_time    = it.stamp;
        i_detector_code = it.code;
        i_crystal_id    = it.crystal;
        i_hit_energy    = it.energy;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        if (advance_tracker(it, v))
            awaited_verdicts.insert(awaited_verdicts.size(), typed ? typed_v : v);
        if (it.op != OP_IGNORED) items_sent++;
    endtask

    // stop offering items, let every verdict drain and the block go idle
    task automatic release_and_settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        do @(posedge i_clk); while (awaited_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_shield_item random_fields();
        t_shield_item it;
        it.op      = OP_W'($urandom_range(OP_START, OP_IGNORED));
        it.stamp   = TIME_W'({$urandom, $urandom});
        it.code    = CODE_W'($urandom);
        it.crystal = CRYSTAL_W'($urandom);
        it.energy  = ENERGY_W'($urandom);
        return it;
    endfunction

    // energies cluster around the threshold so both sides of it are hit
    function automatic logic [ENERGY_W-1:0] pick_energy();
        int e;
        case ($urandom_range(0, 5))
            0:       e = 0;
            1:       e = 65535;
            2, 3:    e = int'(energy_floor) + int'($urandom_range(0, 2)) - 1;
            default: e = int'($urandom_range(0, 65535));
        endcase
        if (e < 0) e = 0;
        if (e > 65535) e = 65535;
        return ENERGY_W'(e);
    endfunction

    // next start time, stepped on the scale of the current windows
    function automatic logic [TIME_W-1:0] advance_clock();
        longint advance;
        longint dead_span;
        dead_span = longint'(lead_ticks) + longint'(trail_ticks) +
                    longint'(channel_ticks) * 8 + longint'(floor_ticks) + 2;
        advance = 0;
        case ($urandom_range(0, 9))
            0:       advance = 0;
            1, 2:    advance = longint'($urandom_range(0, 8));
            3:       advance = longint'($urandom_range(0, 32'(lead_ticks) + 2));
            4:       advance = longint'(window_ticks) - 1 + longint'($urandom_range(0, 2));
            5, 6:    advance = longint'($urandom_range(0, 32'(dead_span)));
            7:       advance = longint'($urandom_range(0, 2 * 32'(window_ticks) + 2));
            8:       advance = -longint'($urandom_range(0, 20));   // time going back
            default: begin
                if ($urandom_range(0, 3) == 0) start_ticks = TIME_W'({$urandom, $urandom});
                else advance = longint'($urandom_range(0, 100));
            end
        endcase
        start_ticks = TIME_W'(longint'(start_ticks) + advance);
        return start_ticks;
    endfunction

    // mostly full events (start, hits, end) with random content, some noise
    task automatic send_random_event();
        t_shield_item it;
        int           hits;
        if ($urandom_range(0, 99) < 15) begin
            // noise: any operation, possibly out of sequence
            it = random_fields();
            send_item(it, 1'b0, NO_VERDICT);
        end else begin
            it       = random_fields();
            it.op    = OP_START;
            it.stamp = advance_clock();
            send_item(it, 1'b0, NO_VERDICT);
            hits = int'($urandom_range(0, 6));
            repeat (hits) begin
                it      = random_fields();
                it.op   = OP_HIT;
                if ($urandom_range(0, 9) != 0)
                    it.code = CODE_W'($urandom_range(DET_X0, DET_Z1));
                else
                    it.code = CODE_W'($urandom_range(DET_UNUSED_LO, DET_UNUSED_HI));
                if ((it.code == DET_Z0 || it.code == DET_Z1) && $urandom_range(0, 1) == 1)
                    it.crystal = Z_CRYSTAL;
                it.energy = pick_energy();
                send_item(it, 1'b0, NO_VERDICT);
            end
            // now and then the end is missing or repeated
            if ($urandom_range(0, 9) != 0) begin
                it    = random_fields();
                it.op = OP_END;
                send_item(it, 1'b0, NO_VERDICT);
                if ($urandom_range(0, 9) == 0) send_item(it, 1'b0, NO_VERDICT);
            end
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_ticks();
        case ($urandom_range(0, 3))
            0:       return CFG_W'($urandom_range(0, 16));
            1, 2:    return CFG_W'($urandom_range(0, 4000));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    task automatic configure_phase(input int phase);
        logic [THR_W-1:0] thr;
        logic [CFG_W-1:0] ticks [5];
        foreach (ticks[i]) ticks[i] = pick_ticks();
        case ($urandom_range(0, 9))
            0:       thr = '1;
            1:       thr = THR_W'(65535);
            2:       thr = THR_W'($urandom);
            default: thr = THR_W'($urandom_range(0, 4000));
        endcase
        case (phase)
            // all at the bottom, then all timing at the top
            0: begin
                thr = '1;
                foreach (ticks[i]) ticks[i] = '0;
            end
            1: begin
                thr = '1;
                foreach (ticks[i]) ticks[i] = '1;
            end
            // threshold at the top: every hit is dropped
            2: thr = THR_W'(65535);
            default: ;
        endcase
        release_and_settle();
        write_register(CFG_ENERGY_THRESHOLD, {(CFG_W - THR_W)'($urandom), thr});
        write_register(CFG_CHANNEL_DEAD, ticks[0]);
        write_register(CFG_VETO_WINDOW, ticks[1]);
        write_register(CFG_PULSE_FLOOR, ticks[2]);
        write_register(CFG_DELAY_BEFORE, ticks[3]);
        write_register(CFG_DELAY_AFTER, ticks[4]);
        if ($urandom_range(0, 1) == 1)
            write_register(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                           CFG_W'($urandom));
        // no idling at all in the last phase
        if (phase == RANDOM_PHASES - 1) begin
            gap_pct   = 0;
            stall_pct = 0;
        end else begin
            gap_pct   = idle_levels[$urandom_range(0, 3)];
            stall_pct = idle_levels[$urandom_range(0, 3)];
        end
    endtask

    // result side back-pressure in bursts
    initial begin
        i_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            i_ready = 1'b1;
        end
    end

    // compare every taken result with the oldest awaited verdict
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (awaited_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: veto=%0b dead=%0b end=%0h",
                             o_has_veto, o_shield_dead, o_dead_time_end);
            end else begin
                head_verdict = awaited_verdicts.pop_front();
                if (o_has_veto !== head_verdict.has_veto ||
                    o_shield_dead !== head_verdict.shield_dead ||
                    o_dead_time_end !== head_verdict.dead_time_end) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: expected veto=%0b dead=%0b end=%0h, got %0b %0b %0h",
                                 head_verdict.has_veto, head_verdict.shield_dead,
                                 head_verdict.dead_time_end, o_has_veto, o_shield_dead,
                                 o_dead_time_end);
                end
            end
        end
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("shield_veto_deadtime_tracker test failed");
            $finish;
        end
    end

    initial begin
        bit   in_cfg;
        t_row row;
        int   phase_end;
        in_cfg          = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_operation     = OP_START;
        i_event_time    = '0;
        i_detector_code = DET_X0;
        i_crystal_id    = '0;
        i_hit_energy    = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_ENERGY_THRESHOLD;
        i_cfg_data      = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, light idling on both sides
        gap_pct   = 25;
        stall_pct = 25;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                // registers change only once the block has gone quiet
                if (!in_cfg) release_and_settle();
                in_cfg = 1'b1;
                write_register(row.wr.idx, row.wr.data);
            end else begin
                in_cfg = 1'b0;
                send_item(row.item, row.kind == ROW_CHECKED, row.want);
            end
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            configure_phase(phase);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) send_random_event();
        end

        release_and_settle();
        if (mismatch_count == 0 && awaited_verdicts.size() == 0)
            $display("shield_veto_deadtime_tracker test passed");
        else
            $display("shield_veto_deadtime_tracker test failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/shvdt_pkg.sv
rtl/core/shvdt_queue.sv
rtl/core/shvdt_front.sv
rtl/core/shvdt_back.sv
rtl/core/shield_veto_deadtime_tracker.sv
tb/shield_veto_deadtime_tracker_tb.sv
